/* rtl/core/rsa_pkg.sv */
// Shared widths and codes for the running statistics accumulator.
`default_nettype none

package rsa_pkg;

   // Field widths
   localparam int DATA_W  = 16;
   localparam int COUNT_W = 20;
   localparam int FRAC_W  = 8;
   localparam int SUM_W   = DATA_W + COUNT_W;
   localparam int SQ_W    = 2 * DATA_W - 2 + COUNT_W;
   localparam int Q8_W    = DATA_W + FRAC_W;

   // Serial multiplier: product of an A operand and a B operand, B scanned LSB first
   localparam int MUL_A_W = (SQ_W > SUM_W) ? SQ_W : SUM_W;
   localparam int MUL_B_W = (COUNT_W > SUM_W) ? COUNT_W : SUM_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Deviation numerator n*sumsq - sum^2 and its Q16 scaling
   localparam int DEV_SHIFT = 2 * FRAC_W;
   localparam int DIFF_W    = COUNT_W + SQ_W;

   // Serial divider and square root
   localparam int DIV_N_W = DIFF_W + DEV_SHIFT;
   localparam int DIV_D_W = 2 * COUNT_W;
   localparam int RT_W    = DIV_N_W / 2;

   // Request opcodes
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

endpackage

`default_nettype wire

/* rtl/core/rsa_mul_serial.sv */
// Shift-and-add multiplier that consumes one multiplier bit per cycle.
`default_nettype none

module rsa_mul_serial (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rsa_pkg::MUL_A_W-1:0] a,
   input  wire logic [rsa_pkg::MUL_B_W-1:0] b,
   output logic                             busy,
   output logic      [rsa_pkg::PROD_W-1:0]  product
);

   localparam int CNT_W = $clog2(rsa_pkg::MUL_B_W + 1);

   logic                         busy_ff, busy_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [rsa_pkg::PROD_W-1:0]   acc_ff, acc_in;
   logic [rsa_pkg::MUL_A_W-1:0]  a_ff, a_in;
   logic [rsa_pkg::MUL_B_W-1:0]  b_ff, b_in;
   logic [rsa_pkg::MUL_A_W:0]    part_sum;

   always_comb begin
      part_sum = {1'b0, acc_ff[rsa_pkg::PROD_W-1:rsa_pkg::MUL_B_W]}
               + (b_ff[0] ? {1'b0, a_ff} : '0);
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(rsa_pkg::MUL_B_W);
         acc_in  = '0;
         a_in    = a;
         b_in    = b;
      end else if (busy_ff) begin
         // add the partial product on top, then shift one bit right
         acc_in  = {part_sum, acc_ff[rsa_pkg::MUL_B_W-1:1]};
         b_in    = {1'b0, b_ff[rsa_pkg::MUL_B_W-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign busy    = busy_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

/* rtl/core/rsa_div_serial.sv */
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module rsa_div_serial (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rsa_pkg::DIV_N_W-1:0] dividend,
   input  wire logic [rsa_pkg::DIV_D_W-1:0] divisor,
   output logic                             busy,
   output logic      [rsa_pkg::DIV_N_W-1:0] quotient
);

   localparam int CNT_W = $clog2(rsa_pkg::DIV_N_W + 1);

   logic                         busy_ff, busy_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [rsa_pkg::DIV_N_W-1:0]  num_ff, num_in;
   logic [rsa_pkg::DIV_D_W-1:0]  den_ff, den_in;
   logic [rsa_pkg::DIV_D_W-1:0]  rem_ff, rem_in;
   logic [rsa_pkg::DIV_D_W:0]    rem_shift;
   logic [rsa_pkg::DIV_D_W:0]    rem_sub;
   logic                         fits;

   always_comb begin
      rem_shift = {rem_ff, num_ff[rsa_pkg::DIV_N_W-1]};
      fits      = (rem_shift >= {1'b0, den_ff});
      rem_sub   = rem_shift - {1'b0, den_ff};
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(rsa_pkg::DIV_N_W);
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // dividend bits leave at the top, quotient bits enter at the bottom
         rem_in  = fits ? rem_sub[rsa_pkg::DIV_D_W-1:0]
                        : rem_shift[rsa_pkg::DIV_D_W-1:0];
         num_in  = {num_ff[rsa_pkg::DIV_N_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign quotient = num_ff;

endmodule

`default_nettype wire

/* rtl/core/rsa_sqrt_serial.sv */
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none

module rsa_sqrt_serial (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rsa_pkg::DIV_N_W-1:0] radicand,
   output logic                             busy,
   output logic      [rsa_pkg::RT_W-1:0]    root
);

   localparam int CNT_W = $clog2(rsa_pkg::RT_W + 1);

   logic                         busy_ff, busy_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [rsa_pkg::DIV_N_W-1:0]  rad_ff, rad_in;
   logic [rsa_pkg::RT_W-1:0]     root_ff, root_in;
   logic [rsa_pkg::RT_W:0]       rem_ff, rem_in;
   logic [rsa_pkg::RT_W+2:0]     rem_shift;
   logic [rsa_pkg::RT_W+2:0]     trial;
   logic [rsa_pkg::RT_W+2:0]     rem_sub;
   logic                         fits;

   always_comb begin
      rem_shift = {rem_ff, rad_ff[rsa_pkg::DIV_N_W-1:rsa_pkg::DIV_N_W-2]};
      trial     = {1'b0, root_ff, 2'b01};
      fits      = (rem_shift >= trial);
      rem_sub   = rem_shift - trial;
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      rad_in    = rad_ff;
      root_in   = root_ff;
      rem_in    = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(rsa_pkg::RT_W);
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         // bring down two radicand bits, try root*4+1
         rem_in  = fits ? rem_sub[rsa_pkg::RT_W:0] : rem_shift[rsa_pkg::RT_W:0];
         root_in = {root_ff[rsa_pkg::RT_W-2:0], fits};
         rad_in  = {rad_ff[rsa_pkg::DIV_N_W-3:0], 2'b00};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

/* rtl/core/running_statistics_accumulator.sv */
// Top level: running count, sum, sum of squares, min, max, mean and deviation.
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  opcode (add or clear), signed sample
// rsp_      out        rsp_valid / rsp_stall  count, sum, square sum, min, max,
//                                             mean Q8, deviation Q8, overflowed
//
// Each request runs through these steps from acceptance to a loaded result: accumulate,
// launch, multiply, difference, divide, root and load. The bit-serial deviation divider
// and square root dominate that time; n*sumsq and sum^2 run on two serial multipliers
// side by side, the mean divider runs in the shadow. The load waits while rsp_stall
// holds the previous result. req_stall is high while a request is in work; the next
// request is taken at the earliest once the result is loaded and the machine is idle,
// even while rsp_stall holds the result.
// Reset (synchronous) clears every statistic and drops any request in work.

module running_statistics_accumulator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_opcode,
   input  wire logic signed [rsa_pkg::DATA_W-1:0] req_sample,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic        [rsa_pkg::COUNT_W-1:0]     rsp_sample_total,
   output logic signed [rsa_pkg::SUM_W-1:0]       rsp_value_sum,
   output logic        [rsa_pkg::SQ_W-1:0]        rsp_square_sum,
   output logic signed [rsa_pkg::DATA_W-1:0]      rsp_smallest,
   output logic signed [rsa_pkg::DATA_W-1:0]      rsp_largest,
   output logic signed [rsa_pkg::Q8_W-1:0]        rsp_mean_q8,
   output logic        [rsa_pkg::Q8_W-1:0]        rsp_deviation_q8,
   output logic                                   rsp_overflowed
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_ACCUM  = 8'b0000_0010,
      S_LAUNCH = 8'b0000_0100,
      S_MUL    = 8'b0000_1000,
      S_DIFF   = 8'b0001_0000,
      S_DIV    = 8'b0010_0000,
      S_ROOT   = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Latched request
   logic                              opcode_ff, opcode_in;
   logic signed [rsa_pkg::DATA_W-1:0] sample_ff, sample_in;

   // Statistics
   logic        [rsa_pkg::COUNT_W-1:0] count_ff, count_in;
   logic signed [rsa_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic        [rsa_pkg::SQ_W-1:0]    sumsq_ff, sumsq_in;
   logic signed [rsa_pkg::DATA_W-1:0]  min_ff, min_in;
   logic signed [rsa_pkg::DATA_W-1:0]  max_ff, max_in;
   logic                               dropped_ff, dropped_in;

   // Deviation denominator n*(n-1)
   logic [rsa_pkg::DIV_D_W-1:0] dev_den_ff, dev_den_in;

   // Result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic        [rsa_pkg::COUNT_W-1:0] out_count_ff, out_count_in;
   logic signed [rsa_pkg::SUM_W-1:0]   out_sum_ff, out_sum_in;
   logic        [rsa_pkg::SQ_W-1:0]    out_sumsq_ff, out_sumsq_in;
   logic signed [rsa_pkg::DATA_W-1:0]  out_min_ff, out_min_in;
   logic signed [rsa_pkg::DATA_W-1:0]  out_max_ff, out_max_in;
   logic signed [rsa_pkg::Q8_W-1:0]    out_mean_ff, out_mean_in;
   logic        [rsa_pkg::Q8_W-1:0]    out_dev_ff, out_dev_in;
   logic                               out_drop_ff, out_drop_in;

   // Combinational helpers
   logic                               req_take;
   logic                               rsp_free;
   logic [rsa_pkg::DATA_W-1:0]         sample_mag;
   logic [2*rsa_pkg::DATA_W-1:0]       sample_sq;
   logic [rsa_pkg::COUNT_W-1:0]        count_inc;
   logic [rsa_pkg::SUM_W-1:0]          sum_mag;
   logic [rsa_pkg::COUNT_W-1:0]        count_dec;
   logic [rsa_pkg::PROD_W-1:0]         dev_diff;
   logic [rsa_pkg::DIV_N_W-1:0]        dev_num;
   logic [rsa_pkg::Q8_W-1:0]           mean_mag;
   logic signed [rsa_pkg::Q8_W-1:0]    mean_val;
   logic [rsa_pkg::Q8_W-1:0]           dev_val;

   // Unit controls
   logic                               launch;
   logic                               dev_div_start;
   logic                               root_start;
   logic                               mul_nq_busy, mul_ss_busy;
   logic                               mean_div_busy, dev_div_busy, root_busy;
   logic [rsa_pkg::PROD_W-1:0]         prod_nq, prod_ss;
   logic [rsa_pkg::DIV_N_W-1:0]        mean_quot, dev_quot;
   logic [rsa_pkg::RT_W-1:0]           root_val;

   assign req_take      = req_valid && !req_stall;
   assign rsp_free      = !rsp_valid_ff || !rsp_stall;
   assign launch        = (state_ff == S_LAUNCH);
   assign dev_div_start = (state_ff == S_DIFF);
   assign root_start    = (state_ff == S_DIV) && !dev_div_busy;

   assign sum_mag   = sum_ff[rsa_pkg::SUM_W-1] ? rsa_pkg::SUM_W'(-sum_ff)
                                               : rsa_pkg::SUM_W'(sum_ff);
   assign count_dec = count_ff - 1'b1;

   // n*sumsq - sum^2 is never negative; scale it to Q16 for the root
   assign dev_diff = prod_nq - prod_ss;
   assign dev_num  = {dev_diff[rsa_pkg::DIFF_W-1:0], {rsa_pkg::DEV_SHIFT{1'b0}}};

   rsa_mul_serial u_mul_nq (
      .clock   (clock),
      .reset   (reset),
      .start   (launch),
      .a       (rsa_pkg::MUL_A_W'(sumsq_ff)),
      .b       (rsa_pkg::MUL_B_W'(count_ff)),
      .busy    (mul_nq_busy),
      .product (prod_nq)
   );

   rsa_mul_serial u_mul_ss (
      .clock   (clock),
      .reset   (reset),
      .start   (launch),
      .a       (rsa_pkg::MUL_A_W'(sum_mag)),
      .b       (rsa_pkg::MUL_B_W'(sum_mag)),
      .busy    (mul_ss_busy),
      .product (prod_ss)
   );

   rsa_div_serial u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (launch),
      .dividend (rsa_pkg::DIV_N_W'({sum_mag, {rsa_pkg::FRAC_W{1'b0}}})),
      .divisor  (rsa_pkg::DIV_D_W'(count_ff)),
      .busy     (mean_div_busy),
      .quotient (mean_quot)
   );

   rsa_div_serial u_dev_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dev_div_start),
      .dividend (dev_num),
      .divisor  (dev_den_ff),
      .busy     (dev_div_busy),
      .quotient (dev_quot)
   );

   rsa_sqrt_serial u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (dev_quot),
      .busy     (root_busy),
      .root     (root_val)
   );

   // Final mean and deviation from the unit outputs
   always_comb begin
      mean_mag = mean_quot[rsa_pkg::Q8_W-1:0];
      if (count_ff == '0) begin
         mean_val = '0;
      end else if (sum_ff[rsa_pkg::SUM_W-1]) begin
         mean_val = signed'(rsa_pkg::Q8_W'(0) - mean_mag);
      end else begin
         mean_val = signed'(mean_mag);
      end

      if (count_ff < rsa_pkg::COUNT_W'(2)) begin
         dev_val = '0;
      end else if (root_val > {{(rsa_pkg::RT_W-rsa_pkg::Q8_W){1'b0}},
                               {rsa_pkg::Q8_W{1'b1}}}) begin
         dev_val = '1;  // saturate
      end else begin
         dev_val = root_val[rsa_pkg::Q8_W-1:0];
      end
   end

   always_comb begin
      sample_mag = sample_ff[rsa_pkg::DATA_W-1] ? rsa_pkg::DATA_W'(-sample_ff)
                                                : rsa_pkg::DATA_W'(sample_ff);
      sample_sq  = sample_mag * sample_mag;
      count_inc  = count_ff + 1'b1;

      state_in     = state_ff;
      opcode_in    = opcode_ff;
      sample_in    = sample_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      sumsq_in     = sumsq_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      dropped_in   = dropped_ff;
      dev_den_in   = dev_den_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_count_in = out_count_ff;
      out_sum_in   = out_sum_ff;
      out_sumsq_in = out_sumsq_ff;
      out_min_in   = out_min_ff;
      out_max_in   = out_max_ff;
      out_mean_in  = out_mean_ff;
      out_dev_in   = out_dev_ff;
      out_drop_in  = out_drop_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               opcode_in = req_opcode;
               sample_in = req_sample;
               state_in  = S_ACCUM;
            end
         end
         S_ACCUM: begin
            if (opcode_ff == rsa_pkg::OP_CLEAR) begin
               count_in   = '0;
               sum_in     = '0;
               sumsq_in   = '0;
               min_in     = '0;
               max_in     = '0;
               dropped_in = 1'b0;
            end else if (count_ff == {rsa_pkg::COUNT_W{1'b1}}) begin
               // count is full: drop the sample, raise the flag
               dropped_in = 1'b1;
            end else begin
               count_in = count_inc;
               sum_in   = sum_ff + rsa_pkg::SUM_W'(sample_ff);
               sumsq_in = sumsq_ff + rsa_pkg::SQ_W'(sample_sq);
               if (count_inc < rsa_pkg::COUNT_W'(2)) begin
                  min_in = sample_ff;
                  max_in = sample_ff;
               end else if (sample_ff < min_ff) begin
                  min_in = sample_ff;
               end else if (sample_ff > max_ff) begin
                  max_in = sample_ff;
               end
            end
            state_in = S_LAUNCH;
         end
         S_LAUNCH: begin
            dev_den_in = count_ff * count_dec;
            state_in   = S_MUL;
         end
         S_MUL: begin
            if (!mul_nq_busy && !mul_ss_busy) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!dev_div_busy) begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            if (!root_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the result register is free and the mean divider is done, then load it
            if (rsp_free && !mean_div_busy) begin
               rsp_valid_in = 1'b1;
               out_count_in = count_ff;
               out_sum_in   = sum_ff;
               out_sumsq_in = sumsq_ff;
               out_min_in   = min_ff;
               out_max_in   = max_ff;
               out_mean_in  = mean_val;
               out_dev_in   = dev_val;
               out_drop_in  = dropped_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sumsq_ff     <= sumsq_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff    <= opcode_in;
      sample_ff    <= sample_in;
      dev_den_ff   <= dev_den_in;
      out_count_ff <= out_count_in;
      out_sum_ff   <= out_sum_in;
      out_sumsq_ff <= out_sumsq_in;
      out_min_ff   <= out_min_in;
      out_max_ff   <= out_max_in;
      out_mean_ff  <= out_mean_in;
      out_dev_ff   <= out_dev_in;
      out_drop_ff  <= out_drop_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_total = out_count_ff;
   assign rsp_value_sum    = out_sum_ff;
   assign rsp_square_sum   = out_sumsq_ff;
   assign rsp_smallest     = out_min_ff;
   assign rsp_largest      = out_max_ff;
   assign rsp_mean_q8      = out_mean_ff;
   assign rsp_deviation_q8 = out_dev_ff;
   assign rsp_overflowed   = out_drop_ff;

endmodule

`default_nettype wire
